FILE: rtl/coin_acceptor_lockout_pulse_core_defines.svh
// Assertion macros for the coin acceptor core.
`ifndef COIN_ACCEPTOR_LOCKOUT_PULSE_CORE_DEFINES_SVH
`define COIN_ACCEPTOR_LOCKOUT_PULSE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CALP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CALP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/calp_pkg.sv
// Package: types, constants and the pence table for the coin acceptor core.
`timescale 1ns / 1ps
`default_nettype none
package calp_pkg;

  localparam int NUM_COINS_DEF = 8;
  localparam int NUM_DENOMS    = 13;

  localparam logic [31:0] LOCK_CYCLES_RST  = 32'd2000000;
  localparam logic [3:0]  FIRST_TOKEN_CODE = 4'd7;

  // Word layouts
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 144;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_COIN = 2'd1,
    OP_PORT = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_PULSE_CYCLES = 3'd0;
  localparam logic [2:0] CFG_LOCK_CYCLES  = 3'd1;
  localparam logic [2:0] CFG_VALUE_TABLE  = 3'd2;
  localparam logic [2:0] CFG_LOCKOUT_BITS = 3'd3;
  localparam logic [2:0] CFG_ENABLE_MASK  = 3'd4;

  // Pence value of a denomination code; this value is also the credit code.
  function automatic logic [7:0] pence_of(input logic [3:0] code);
    logic [7:0] p;
    unique case (code)
      4'd0:          p = 8'h02;
      4'd1, 4'd7:    p = 8'h05;
      4'd2, 4'd8:    p = 8'h0A;
      4'd3, 4'd9:    p = 8'h14;
      4'd4, 4'd10:   p = 8'h32;
      4'd5, 4'd11:   p = 8'h64;
      4'd6, 4'd12:   p = 8'hC8;
      default:       p = 8'h00;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/coin_acceptor_lockout_pulse_core.sv
// Top level: coin acceptor with credit pulse, lock period and lockout lamps.
//
//  channel | dir | handshake          | contents
//  in_     | in  | in_tvalid/tready   | tuser op, tdata coin/elapsed/port
//  out_    | out | out_tvalid/tready  | tdata: one result word per input word
//  cfg_    | in  | cfg_we             | register index + 32-bit data
//
// Each word is processed as it is accepted, and the result lands in the output
// register on the same edge.
// The output register frees up in the cycle it is taken, so a new word is
// accepted every cycle while out_tready is high.
// rst_n is synchronous; it clears all state but out_data_r and loads lock_cycles = 2000000.
// Stalls on the output hold the result and block input until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "coin_acceptor_lockout_pulse_core_defines.svh"
module coin_acceptor_lockout_pulse_core
  import calp_pkg::*;
#(
  parameter int NUM_COINS = NUM_COINS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // tuser: op[1:0]
  // tdata: coin_index[2:0], elapsed_cycles[18:3], port_value[26:19], zero[31:27]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [1:0]             in_tuser,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tdata: accepted[0], pulse_active[1], credit_code[9:2], lamp_cash[10],
  //        lamp_token[11], coins_total[43:12], tokens_total[75:44],
  //        grand_total[107:76], denomination_count[139:108], zero[143:140]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_addr,
  input  wire logic [31:0]            cfg_wdata
);

  // Configuration
  logic [31:0]            pulse_cycles_r;
  logic [31:0]            lock_cycles_r;
  logic [4*NUM_COINS-1:0] value_tbl_r;
  logic [3*NUM_COINS-1:0] lockout_tbl_r;
  logic [NUM_COINS-1:0]   enable_r;

  // State
  logic [31:0] pulse_r, pulse_nxt;
  logic [31:0] lock_r, lock_nxt;
  logic [7:0]  port_r, port_nxt;
  logic [31:0] denom_r [NUM_DENOMS];
  logic [31:0] cash_r, cash_nxt;
  logic [31:0] token_r, token_nxt;
  logic [31:0] grand_r, grand_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [1:0]  lamp_r, lamp_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  op_t         op;
  logic [2:0]  in_coin;
  logic [15:0] in_elapsed;
  logic [7:0]  in_port;
  logic        in_acc;

  logic [31:0] elapsed32;
  logic        pulse_nz, underrun;
  logic [31:0] lock_base;
  logic        coin_ok;
  logic [3:0]  coin_code;
  logic [2:0]  coin_bit;
  logic        coin_allow;
  logic        counted;
  logic [3:0]  denom_idx;
  logic [7:0]  pence;
  logic [31:0] count_inc;
  logic        accepted;
  logic        pulse_active;
  logic [31:0] count_out;

  assign op         = op_t'(in_tuser);
  assign in_coin    = in_tdata[2:0];
  assign in_elapsed = in_tdata[18:3];
  assign in_port    = in_tdata[26:19];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Tick path
  assign elapsed32 = {16'd0, in_elapsed};
  assign pulse_nz  = (pulse_r != 32'd0);
  assign underrun  = pulse_nz && (elapsed32 > pulse_r);
  assign lock_base = underrun ? lock_cycles_r : lock_r;

  // Coin lookup; slots at or above NUM_COINS never match
  always_comb begin
    coin_code = '0;
    coin_bit  = '0;
    for (int i = 0; i < NUM_COINS; i++) begin
      if (in_coin == 3'(i)) begin
        coin_code = value_tbl_r[i*4 +: 4];
        coin_bit  = lockout_tbl_r[i*3 +: 3];
      end
    end
  end

  assign coin_ok    = ({1'b0, in_coin} < 4'(NUM_COINS));
  assign coin_allow = coin_ok && !pulse_nz && (lock_r == 32'd0) &&
                      port_r[coin_bit] && (pulse_cycles_r != 32'd0);
  assign counted    = (coin_code < 4'(NUM_DENOMS));
  assign denom_idx  = counted ? coin_code : 4'd0;
  assign pence      = pence_of(coin_code);
  assign count_inc  = denom_r[denom_idx] + 32'd1;

  always_comb begin
    pulse_nxt    = pulse_r;
    lock_nxt     = lock_r;
    port_nxt     = port_r;
    cash_nxt     = cash_r;
    token_nxt    = token_r;
    grand_nxt    = grand_r;
    code_nxt     = code_r;
    lamp_nxt     = lamp_r;
    accepted     = 1'b0;
    pulse_active = 1'b0;
    count_out    = '0;
    unique case (op)
      OP_TICK: begin
        pulse_active = pulse_nz;
        if (underrun) begin
          pulse_nxt = '0;
        end else if (pulse_nz) begin
          pulse_nxt = pulse_r - elapsed32;
        end
        lock_nxt = (elapsed32 > lock_base) ? 32'd0 : lock_base - elapsed32;
      end
      OP_COIN: begin
        if (coin_allow) begin
          accepted  = 1'b1;
          pulse_nxt = pulse_cycles_r;
          if (counted) begin
            count_out = count_inc;
            code_nxt  = pence;
            grand_nxt = grand_r + {24'd0, pence};
            if (coin_code < FIRST_TOKEN_CODE) begin
              cash_nxt = cash_r + {24'd0, pence};
            end else begin
              token_nxt = token_r + {24'd0, pence};
            end
          end
        end
      end
      OP_PORT: begin
        port_nxt = in_port;
        lamp_nxt = '0;
        for (int i = 0; i < NUM_COINS; i++) begin
          if (enable_r[i] && in_port[lockout_tbl_r[i*3 +: 3]]) begin
            if (value_tbl_r[i*4 +: 4] < FIRST_TOKEN_CODE) begin
              lamp_nxt[0] = 1'b1;
            end else begin
              lamp_nxt[1] = 1'b1;
            end
          end
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign out_data_nxt = {4'd0, count_out, grand_nxt, token_nxt, cash_nxt,
                         lamp_nxt[1], lamp_nxt[0], code_nxt, pulse_active, accepted};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_cycles_r <= '0;
      lock_cycles_r  <= LOCK_CYCLES_RST;
      value_tbl_r    <= '0;
      lockout_tbl_r  <= '0;
      enable_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PULSE_CYCLES: pulse_cycles_r <= cfg_wdata;
        CFG_LOCK_CYCLES:  lock_cycles_r  <= cfg_wdata;
        CFG_VALUE_TABLE:  value_tbl_r    <= cfg_wdata[4*NUM_COINS-1:0];
        CFG_LOCKOUT_BITS: lockout_tbl_r  <= cfg_wdata[3*NUM_COINS-1:0];
        CFG_ENABLE_MASK:  enable_r       <= cfg_wdata[NUM_COINS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Acceptor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= '0;
      lock_r  <= '0;
      port_r  <= '0;
      cash_r  <= '0;
      token_r <= '0;
      grand_r <= '0;
      code_r  <= '0;
      lamp_r  <= '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
        denom_r[i] <= '0;
      end
    end else if (in_acc) begin
      pulse_r <= pulse_nxt;
      lock_r  <= lock_nxt;
      port_r  <= port_nxt;
      cash_r  <= cash_nxt;
      token_r <= token_nxt;
      grand_r <= grand_nxt;
      code_r  <= code_nxt;
      lamp_r  <= lamp_nxt;
      if (op == OP_COIN && coin_allow && counted) begin
        denom_r[denom_idx] <= count_inc;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Pulse and lock never run together
  `CALP_ASSERT_NOW(a_timers_exclusive, 1'b1, (pulse_r == 32'd0) || (lock_r == 32'd0), "pulse and lock both running")
  // Accepted coin always starts a pulse
  `CALP_ASSERT_NEXT(a_coin_starts_pulse, in_acc && op == OP_COIN && coin_allow, pulse_r != 32'd0, "accepted coin left no pulse")
  // Grand total tracks the two sums
  `CALP_ASSERT_NOW(a_grand_sum, 1'b1, grand_r == cash_r + token_r, "grand total out of step with sums")
  // Lamps only move on a port write
  `CALP_ASSERT_NEXT(a_lamps_held, in_acc && op != OP_PORT, $stable(lamp_r), "lamps changed without port write")

endmodule
`default_nettype wire
